// File: design/tcw_pkg.sv
// Shared types and constants of the text console character writer.
`default_nettype none
package tcw_pkg;

  // Cell and field widths.
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned CUR_COL_W  = 7;
  localparam int unsigned CUR_ROW_W  = 5;

  // Configuration port.
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic        REG_BLANK_ATTR = 1'b0;

  // Modes.
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Reset values.
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CELL_W-1:0]    cell_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT_RD,
    ST_PUT_WR,
    ST_LINE,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_BS,
    ST_READ,
    ST_FINISH
  } ctrl_state_e;

endpackage
`default_nettype wire

// File: design/text_console_char_writer_top.sv
// Top level of the text console character writer.
//
// Text console over a COLUMNS x ROWS grid of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one memory with one write
// port and one registered read port. Each word on the input channel is a
// mode plus a character code or cell index; each one yields exactly one
// result word with the cursor position after it and, for a read, the cell.
// Steps from accept to result: an ordinary character reads its cell, writes it
// back with the attribute kept and registers the result, with a line step when
// it wraps to the next line; a tab does one such read and write-back per space
// up to the next tab stop, with a line step when it wraps; carriage return, code
// zero and the unused mode go straight to the result; backspace blanks its cell;
// a cell read reads the cell unless it lies past the end of the store; newline
// takes a line step. A wrap or newline on the last row adds a scroll that
// copies COLUMNS*(ROWS-1) cells up a row and fills the last row with blanks;
// clear screen blanks every cell. Words are handled one at a time; the next
// word is taken as soon as the previous result sits in the output register,
// even while that result still waits to be taken. After reset a clearing pass
// writes every cell to a space with attribute 7 with in_ready_o low; the blank
// attribute register on the APB port (byte address 0) may be written then.
`default_nettype none
module text_console_char_writer_top #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire tcw_pkg::in_item_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output tcw_pkg::out_item_t                out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AW        = $clog2(CellCount);

  logic [tcw_pkg::ATTR_W-1:0] blank_attr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  // Blank attribute register.
  tcw_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .blank_attr_o (blank_attr)
  );

  // Sequencer: decode the word, walk the cells, hold the result.
  tcw_ctrl #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .blank_attr_i (blank_attr),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Character cell store.
  tcw_cell_mem #(
    .DEPTH (CellCount),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// File: design/tcw_cell_mem.sv
// Cell store: one write port and one registered read port.
`default_nettype none
module tcw_cell_mem #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/tcw_cfg.sv
// APB register block holding the blank attribute.
`default_nettype none
module tcw_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [tcw_pkg::ATTR_W-1:0]   blank_attr_o
);

  logic [tcw_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic                       hit;

  // Register index is the word address; only one register exists.
  assign hit = (paddr[2] == tcw_pkg::REG_BLANK_ATTR);

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && hit) begin
      attr_d = pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign prdata       = hit ? tcw_pkg::PDATA_W'(attr_q) : '0;
  assign pready       = 1'b1;
  assign blank_attr_o = attr_q;

endmodule
`default_nettype wire

// File: design/tcw_ctrl.sv
// Sequencer: cursor state, read-modify-write of cells, scroll and clear sweeps.
`default_nettype none
module tcw_ctrl #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4,
  parameter int unsigned AW        = 11
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire tcw_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tcw_pkg::out_item_t               out_data_o,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  blank_attr_i,
  output logic                             mem_we_o,
  output logic      [AW-1:0]               mem_waddr_o,
  output logic      [tcw_pkg::CELL_W-1:0]  mem_wdata_o,
  output logic                             mem_re_o,
  output logic      [AW-1:0]               mem_raddr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0]  mem_rdata_i
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned CopyCount = COLUMNS * (ROWS - 1);
  localparam int unsigned CW        = $clog2(COLUMNS);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned ModW      = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int unsigned IdxCmpW   = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;
  localparam int unsigned ColLastMod = (COLUMNS - 1) % TAB_WIDTH;

  localparam logic [CW-1:0]   ColLast  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]   RowLast  = RW'(ROWS - 1);
  localparam logic [AW-1:0]   CellLast = AW'(CellCount - 1);
  localparam logic [AW-1:0]   CopyLast = AW'(CopyCount);
  localparam logic [AW-1:0]   RowStep  = AW'(COLUMNS);
  localparam logic [ModW-1:0] TabLast  = ModW'(TAB_WIDTH - 1);
  localparam logic [ModW-1:0] ModWrap  = ModW'(ColLastMod);

  tcw_pkg::ctrl_state_e state_q, state_d;

  logic [AW-1:0]                sweep_q, sweep_d;
  logic [AW-1:0]                wr_addr_q, wr_addr_d;
  logic                         wr_pend_q, wr_pend_d;
  logic [CW-1:0]                col_q, col_d;
  logic [ModW-1:0]              mod_q, mod_d;
  logic [RW-1:0]                line_q, line_d;
  logic [AW-1:0]                base_q, base_d;
  logic [tcw_pkg::CHAR_W-1:0]   char_q, char_d;
  logic                         tab_q, tab_d;
  logic [tcw_pkg::CELL_W-1:0]   value_q, value_d;
  logic                         out_valid_q, out_valid_d;
  tcw_pkg::out_item_t           out_data_q, out_data_d;

  logic                         accept;
  logic                         idx_ok;
  logic                         col_wrap;
  logic                         slot_free;
  logic [AW-1:0]                cur_addr;
  logic [tcw_pkg::CELL_W-1:0]   blank;

  assign accept    = in_valid_i && (state_q == tcw_pkg::ST_IDLE);
  assign idx_ok    = IdxCmpW'(in_data_i.cell_index) < IdxCmpW'(CellCount);
  assign col_wrap  = (col_q == ColLast);
  assign slot_free = !out_valid_q || out_ready_i;
  assign cur_addr  = base_q + AW'(col_q);
  assign blank     = {blank_attr_i, tcw_pkg::CHAR_SPACE};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      tcw_pkg::ST_INIT: begin
        if (sweep_q == CellLast) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.mode)
            tcw_pkg::MODE_WRITE: begin
              unique case (in_data_i.char_code) inside
                tcw_pkg::CHAR_NUL, tcw_pkg::CHAR_CR: state_d = tcw_pkg::ST_FINISH;
                tcw_pkg::CHAR_LF:                    state_d = tcw_pkg::ST_LINE;
                tcw_pkg::CHAR_BS:                    state_d = tcw_pkg::ST_BS;
                default:                             state_d = tcw_pkg::ST_PUT_RD;
              endcase
            end
            tcw_pkg::MODE_CLEAR: state_d = tcw_pkg::ST_CLEAR;
            tcw_pkg::MODE_READ:  state_d = idx_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_FINISH;
            default:             state_d = tcw_pkg::ST_FINISH;
          endcase
        end
      end
      tcw_pkg::ST_PUT_RD: state_d = tcw_pkg::ST_PUT_WR;
      tcw_pkg::ST_PUT_WR: begin
        if (col_wrap) begin
          state_d = tcw_pkg::ST_LINE;
        end else if (tab_q && (mod_q != TabLast)) begin
          state_d = tcw_pkg::ST_PUT_RD;
        end else begin
          state_d = tcw_pkg::ST_FINISH;
        end
      end
      tcw_pkg::ST_LINE: begin
        state_d = (line_q == RowLast) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_SCROLL: begin
        if (sweep_q == CopyLast) state_d = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
        if (sweep_q == CellLast) state_d = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_BS:   state_d = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_FINISH: begin
        if (slot_free) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    sweep_d     = sweep_q;
    wr_addr_d   = wr_addr_q;
    wr_pend_d   = wr_pend_q;
    col_d       = col_q;
    mod_d       = mod_q;
    line_d      = line_q;
    base_d      = base_q;
    char_d      = char_q;
    tab_d       = tab_q;
    value_d     = value_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_addr;
    mem_wdata_o = blank;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_addr;
    in_ready_o  = 1'b0;

    unique case (state_q) inside
      tcw_pkg::ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        mem_wdata_o = tcw_pkg::BLANK_RESET;
        sweep_d     = (sweep_q == CellLast) ? '0 : sweep_q + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          value_d = '0;
          tab_d   = (in_data_i.char_code == tcw_pkg::CHAR_TAB);
          char_d  = (in_data_i.char_code == tcw_pkg::CHAR_TAB) ? tcw_pkg::CHAR_SPACE
                                                               : in_data_i.char_code;
          unique case (in_data_i.mode)
            tcw_pkg::MODE_WRITE: begin
              if ((in_data_i.char_code == tcw_pkg::CHAR_LF) ||
                  (in_data_i.char_code == tcw_pkg::CHAR_CR)) begin
                col_d = '0;
                mod_d = '0;
              end else if (in_data_i.char_code == tcw_pkg::CHAR_BS) begin
                // Step back; wrap to the end of the previous line, stop at home.
                if (col_q == '0) begin
                  if (line_q != '0) begin
                    line_d = line_q - 1'b1;
                    base_d = base_q - RowStep;
                    col_d  = ColLast;
                    mod_d  = ModWrap;
                  end
                end else begin
                  col_d = col_q - 1'b1;
                  mod_d = (mod_q == '0) ? TabLast : mod_q - 1'b1;
                end
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              col_d  = '0;
              mod_d  = '0;
              line_d = '0;
              base_d = '0;
            end
            tcw_pkg::MODE_READ: begin
              mem_re_o    = idx_ok;
              mem_raddr_o = AW'(in_data_i.cell_index);
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_PUT_RD: begin
        mem_re_o = 1'b1;
      end
      tcw_pkg::ST_PUT_WR: begin
        // Keep the attribute, replace the character.
        mem_we_o    = 1'b1;
        mem_wdata_o = {mem_rdata_i[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], char_q};
        if (col_wrap) begin
          col_d = '0;
          mod_d = '0;
        end else begin
          col_d = col_q + 1'b1;
          mod_d = (mod_q == TabLast) ? '0 : mod_q + 1'b1;
        end
      end
      tcw_pkg::ST_LINE: begin
        if (line_q != RowLast) begin
          line_d = line_q + 1'b1;
          base_d = base_q + RowStep;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // Read one row below, write it back in the next cycle.
        mem_re_o    = (sweep_q != CopyLast);
        mem_raddr_o = sweep_q + RowStep;
        mem_we_o    = wr_pend_q;
        mem_waddr_o = wr_addr_q;
        mem_wdata_o = mem_rdata_i;
        wr_pend_d   = (sweep_q != CopyLast);
        wr_addr_d   = sweep_q;
        if (sweep_q != CopyLast) sweep_d = sweep_q + 1'b1;
      end
      tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        sweep_d     = (sweep_q == CellLast) ? '0 : sweep_q + 1'b1;
      end
      tcw_pkg::ST_BS: begin
        mem_we_o = 1'b1;
      end
      tcw_pkg::ST_READ: begin
        value_d = mem_rdata_i;
      end
      tcw_pkg::ST_FINISH: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_data_d.cursor_col = tcw_pkg::CUR_COL_W'(col_q);
          out_data_d.cursor_row = tcw_pkg::CUR_ROW_W'(line_q);
          out_data_d.cell_value = value_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_INIT;
      sweep_q     <= '0;
      wr_addr_q   <= '0;
      wr_pend_q   <= 1'b0;
      col_q       <= '0;
      mod_q       <= '0;
      line_q      <= '0;
      base_q      <= '0;
      char_q      <= '0;
      tab_q       <= 1'b0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      wr_addr_q   <= wr_addr_d;
      wr_pend_q   <= wr_pend_d;
      col_q       <= col_d;
      mod_q       <= mod_d;
      line_q      <= line_d;
      base_q      <= base_d;
      char_q      <= char_d;
      tab_q       <= tab_d;
      value_q     <= value_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// File: design/tcw_checker.sv
// Port-level checks of the text console character writer, bound to its top.
`default_nettype none
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire tcw_pkg::out_item_t out_data_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // One word at a time: ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.cursor_row) < ROWS))
    else $error("cursor row out of range");

endmodule

bind text_console_char_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// File: dv/text_console_char_writer_top_tb.sv
// Self-checking testbench for the text console character writer top level.
`default_nettype none
module text_console_char_writer_top_tb;
  import tcw_pkg::*;

  // Geometry of the instance under test.
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned TAB_WIDTH  = 4;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  // Code that the block treats as a no-op mode.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] BLANK_ATTR_ADDR = PADDR_W'(4 * REG_BLANK_ATTR);

  // Run shape: five attribute settings, each with its own share of random words.
  localparam int unsigned PHASES         = 5;
  localparam int unsigned WORDS_PER_PHASE = 350;
  localparam int unsigned QUIET_WORDS    = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  // A clear or a scroll walks the whole store; the stall limit leaves room for that.
  localparam int unsigned STALL_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES  = 50;
  localparam int unsigned PRINT_CAP      = 40;

  // Scoreboard: mirror of the screen, cursor and blank attribute, plus the queue of
  // results still owed by the block.
  class console_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    logic [ATTR_W-1:0] blank_attr;
    int unsigned       col, row;
    out_item_t         pending [$];
    int unsigned       errors, results, scrolls, bs_wraps;
    int unsigned       mode_seen [4];

    function new();
      blank_attr = ATTR_RESET;
      fill_blank();
      col = 0;
      row = 0;
    endfunction

    function logic [CELL_W-1:0] blank_cell();
      return {blank_attr, CHAR_SPACE};
    endfunction

    function void fill_blank();
      foreach (cells[i]) cells[i] = blank_cell();
    endfunction

    // Advance one row; past the bottom, shift everything up and blank the last row.
    function void next_row();
      int unsigned i;
      row++;
      if (row >= ROWS) begin
        for (i = 0; i < COLUMNS * (ROWS - 1); i++) cells[i] = cells[i + COLUMNS];
        for (i = 0; i < COLUMNS; i++) cells[COLUMNS * (ROWS - 1) + i] = blank_cell();
        row = ROWS - 1;
        scrolls++;
      end
    endfunction

    // Replace the character byte, keep the attribute, advance with line wrap.
    function void put_glyph(logic [CHAR_W-1:0] ch);
      int unsigned at;
      at = row * COLUMNS + col;
      cells[at][CHAR_W-1:0] = ch;
      col++;
      if (col >= COLUMNS) begin
        col = 0;
        next_row();
      end
    endfunction

    function void note_input(in_item_t w);
      out_item_t want;
      logic [CELL_W-1:0] value;
      value = '0;
      mode_seen[w.mode]++;
      case (w.mode)
        MODE_WRITE: begin
          case (w.char_code)
            CHAR_NUL: ;
            CHAR_LF: begin
              col = 0;
              next_row();
            end
            CHAR_CR: col = 0;
            CHAR_BS: begin
              if (col != 0) begin
                col--;
              end else if (row != 0) begin
                row--;
                col = COLUMNS - 1;
                bs_wraps++;
              end
              cells[row * COLUMNS + col] = blank_cell();
            end
            CHAR_TAB: begin
              do put_glyph(CHAR_SPACE); while (col % TAB_WIDTH != 0);
            end
            default: put_glyph(w.char_code);
          endcase
        end
        MODE_CLEAR: begin
          fill_blank();
          col = 0;
          row = 0;
        end
        MODE_READ: begin
          if (w.cell_index < CELL_COUNT) value = cells[w.cell_index];
        end
        default: ;
      endcase
      want.cursor_col = CUR_COL_W'(col);
      want.cursor_row = CUR_ROW_W'(row);
      want.cell_value = value;
      pending.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH: %s", what);
    endtask

    task check(out_item_t got);
      out_item_t want;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending (%h)", results, got));
        return;
      end
      want = pending.pop_front();
      if (got.cursor_col !== want.cursor_col)
        report($sformatf("result %0d: cursor_col %0d, want %0d",
                         results, got.cursor_col, want.cursor_col));
      if (got.cursor_row !== want.cursor_row)
        report($sformatf("result %0d: cursor_row %0d, want %0d",
                         results, got.cursor_row, want.cursor_row));
      if (got.cell_value !== want.cell_value)
        report($sformatf("result %0d: cell_value %h, want %h",
                         results, got.cell_value, want.cell_value));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid, in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata, prdata;

  // Idle odds: a burst starts with chance 1/N at each try, zero for none.
  int unsigned send_gap_odds, take_gap_odds;
  bit          hold_request;
  int unsigned quiet_cycles;

  console_scoreboard screen = new();

  text_console_char_writer_top #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: take results, stall in short random bursts, and once hold off for a
  // long stretch so the block backs up into its input.
  always begin : receiver
    int unsigned stall_left;
    bit          hold_done;
    @(negedge clk);
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (take_gap_odds != 0 && $urandom_range(take_gap_odds - 1, 0) == 0) begin
      stall_left = $urandom_range(9, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each word taken from the output against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) screen.check(out_data);
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results owed",
                 quiet_cycles, screen.pending.size());
        $display("text_console_char_writer_top_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic in_item_t char_word(logic [CHAR_W-1:0] ch);
    in_item_t w;
    w.mode = MODE_WRITE;
    w.char_code = ch;
    w.cell_index = IDX_W'($urandom);
    return w;
  endfunction

  function automatic in_item_t read_word(logic [IDX_W-1:0] idx);
    in_item_t w;
    w.mode = MODE_READ;
    w.char_code = CHAR_W'($urandom);
    w.cell_index = idx;
    return w;
  endfunction

  function automatic in_item_t other_word(logic [MODE_W-1:0] m);
    in_item_t w;
    w.mode = m;
    w.char_code = CHAR_W'($urandom);
    w.cell_index = IDX_W'($urandom);
    return w;
  endfunction

  // Offer one word, maybe after a random gap; hold it until the block takes it.
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    @(negedge clk);
    if (send_gap_odds != 0 && $urandom_range(send_gap_odds - 1, 0) == 0) begin
      gap = $urandom_range(10, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    screen.note_input(w);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (screen.pending.size() != 0) @(posedge clk);
  endtask

  // Write the blank attribute over APB, then read it back.
  task automatic program_blank_attr(input logic [ATTR_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BLANK_ATTR_ADDR;
    pwdata <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    screen.blank_attr = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ATTR_W-1:0] !== v)
      screen.report($sformatf("blank attribute reads back %h, want %h",
                              prdata[ATTR_W-1:0], v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [ATTR_W-1:0] attr_plan [PHASES];
    int unsigned       send_plan [PHASES];
    int unsigned       take_plan [PHASES];
    int unsigned       counted, len, pick, r;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;

    attr_plan = '{ATTR_RESET, 8'h00, 8'hFF, 8'h00, 8'h1E};
    attr_plan[3] = ATTR_W'($urandom_range(254, 1));
    send_plan = '{4, 0, 6, 3, 5};
    take_plan = '{5, 0, 3, 8, 4};

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_request = 1'b0;
    send_gap_odds = 0;
    take_gap_odds = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // The first write lands during the clearing pass after reset.
      program_blank_attr(attr_plan[phase]);
      send_gap_odds = send_plan[phase];
      take_gap_odds = take_plan[phase];

      if (phase == 0) begin
        // Directed: reads at the edges of the store and past it, the unused mode,
        // every control code, and backspace and tab across a row boundary.
        send_word(read_word(IDX_W'(0)));
        send_word(read_word(IDX_W'(CELL_COUNT - 1)));
        send_word(read_word(IDX_W'(CELL_COUNT)));
        send_word(read_word('1));
        send_word(in_item_t'('1));
        send_word(char_word(CHAR_NUL));
        send_word(char_word(CHAR_BS));          // stays at the home position
        send_word(char_word(8'h41));
        send_word(char_word(8'hFF));
        send_word(char_word(CHAR_TAB));         // two spaces
        send_word(char_word(CHAR_TAB));         // a full tab stop
        send_word(char_word(CHAR_CR));
        send_word(char_word(CHAR_LF));
        send_word(char_word(CHAR_BS));          // wraps back to the end of row 0
        send_word(char_word(8'h5A));            // last column, wraps to row 1
        send_word(char_word(CHAR_BS));
        send_word(char_word(CHAR_TAB));         // one space, ended by the wrap
        send_word(read_word(IDX_W'(0)));
        send_word(read_word(IDX_W'(COLUMNS - 1)));
        send_word(other_word(MODE_CLEAR));
        send_word(read_word(IDX_W'(0)));
      end

      if (phase == 1) hold_request = 1'b1;

      // Random bursts of well-formed traffic, with some noise mixed in.
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        if (phase == PHASES - 1 && counted + QUIET_WORDS >= WORDS_PER_PHASE) begin
          send_gap_odds = 0;
          take_gap_odds = 0;
        end
        // Open with a run that pushes the cursor off the bottom row.
        pick = (phase == 0 && counted == 0) ? 50 : $urandom_range(99, 0);
        if (pick < 45) begin
          len = $urandom_range(90, 5);
          repeat (len) begin
            r = $urandom_range(99, 0);
            if (r < 5) ch = CHAR_TAB;
            else if (r < 9) ch = CHAR_BS;
            else if (r < 11) ch = CHAR_CR;
            else if (r < 14) ch = CHAR_LF;
            else if (r < 20) ch = CHAR_W'($urandom_range(255, 0));
            else ch = CHAR_W'($urandom_range(126, 32));
            send_word(char_word(ch));
          end
          counted += len;
        end else if (pick < 60) begin
          len = (counted == 0 && phase == 0) ? ROWS + 5 : $urandom_range(12, 1);
          repeat (len) send_word(char_word(CHAR_LF));
          counted += len;
        end else if (pick < 80) begin
          len = $urandom_range(8, 1);
          repeat (len) begin
            case ($urandom_range(3, 0))
              0: idx = IDX_W'($urandom_range(2047, 0));
              1: idx = IDX_W'(screen.row * COLUMNS + $urandom_range(COLUMNS - 1, 0));
              2: idx = IDX_W'((ROWS - 1) * COLUMNS + $urandom_range(COLUMNS - 1, 0));
              default: idx = IDX_W'($urandom_range(CELL_COUNT + 47, CELL_COUNT - 48));
            endcase
            send_word(read_word(idx));
          end
          counted += len;
        end else if (pick < 88) begin
          len = $urandom_range(100, 1);
          repeat (len) send_word(char_word(CHAR_BS));
          counted += len;
        end else if (pick < 92) begin
          send_word(other_word(MODE_CLEAR));
          counted++;
        end else begin
          // Noise: words the block ignores; they do not count.
          repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(1, 0) == 0) send_word(other_word(MODE_UNUSED));
            else send_word(char_word(CHAR_NUL));
          end
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d words: %0d writes, %0d clears, %0d reads, %0d unused-mode",
             screen.results, screen.mode_seen[MODE_WRITE], screen.mode_seen[MODE_CLEAR],
             screen.mode_seen[MODE_READ], screen.mode_seen[MODE_UNUSED]);
    $display("  %0d scrolls, %0d backspace row wraps, %0d blank attributes, %0d mismatches",
             screen.scrolls, screen.bs_wraps, PHASES, screen.errors);
    if (screen.errors == 0) begin
      $display("text_console_char_writer_top_tb: done, clean");
    end else begin
      $display("text_console_char_writer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
